// ===== rtl/core/pedt_pkg.sv =====
package pedt_pkg;

  localparam int CostW = 24;
  localparam int BndW = 32;
  localparam logic [CostW-1:0] AllOnes = 24'hFFFFFF;
  localparam logic [BndW-1:0] BndMax = 32'h7FFFFFFF;
  localparam logic [BndW-1:0] BndMin = 32'h80000000;
  localparam logic [0:0] RegTakeRoot = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_OPS,
    ST_RD_COST,
    ST_DIVIDE,
    ST_DECIDE,
    ST_OUT_RD,
    ST_OUT_VTX,
    ST_OUT_CALC,
    ST_OUT_ROOT,
    ST_OUT_SEND
  } state_t;

endpackage

// ===== rtl/core/pedt_stream_if.sv =====
interface pedt_stream_if;
  logic valid;
  logic ready;
  logic [23:0] cost;
  logic last;

  modport source (output valid, output cost, output last, input ready);
  modport sink (input valid, input cost, input last, output ready);
endinterface

// ===== rtl/core/pedt_ram.sv =====
module pedt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/parabola_envelope_distance_1d.sv =====
// Lower-envelope distance transform over one row of up to MAX_LEN samples.
// Each input transaction adds one cost sample. The first sample of a row is taken
// without a comparison. Any later sample is compared with the top vertex of the
// envelope: the vertex and its boundary are read, then the vertex's cost, and a
// restoring divider finds the crossing point. A sample takes one comparison per
// vertex it pops and one more, and the next sample can be taken in the cycle that
// follows. When in_s.last is set, or the sample fills the last position, the block
// emits one result transaction per position in order. Each result reads the
// envelope in ST_OUT_RD and ST_OUT_VTX, again for each boundary passed on the way
// to its vertex, forms its value in ST_OUT_CALC, takes its square root in
// ST_OUT_ROOT if take_root is set and the value is not saturated, and is then held
// until the sink accepts it. No sample is taken during a comparison or while a row
// is emitted. take_root is written over the APB port at byte address 0, bit 0.
module parabola_envelope_distance_1d #(
  parameter int MAX_LEN = 64
) (
  input  logic          clk,
  input  logic          rst,
  pedt_stream_if.sink   in_s,
  pedt_stream_if.source out_s,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [0:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int HW = 25;
  localparam int DivW = 33;

  pedt_pkg::state_t state, state_next;
  logic take_root;
  logic [AW-1:0] count;
  logic [AW-1:0] q;
  logic [AW-1:0] top;
  logic [AW-1:0] k;
  logic [AW-1:0] p;
  logic row_last;
  logic [pedt_pkg::CostW-1:0] cq;
  logic [AW-1:0] vtx;
  logic signed [pedt_pkg::BndW-1:0] bnd_k;
  logic [5:0] div_cnt;
  logic [AW:0] rem;
  logic [AW:0] den;
  logic [DivW-1:0] quo;
  logic neg;
  logic signed [31:0] s_val;
  logic [AW-1:0] cur_v;
  logic [4:0] rt_cnt;
  logic [31:0] rt_x;
  logic [17:0] rt_rem;
  logic [15:0] rt_root;
  logic [23:0] res;

  logic c_we, v_we, b_we;
  logic [AW-1:0] c_wa, c_ra, v_wa, v_ra, b_wa, b_ra;
  logic [23:0] c_wd, c_rd;
  logic [AW-1:0] v_wd, v_rd;
  logic [31:0] b_wd, b_rd;

  logic take_in;
  logic accept_last;
  logic pop;
  logic step;
  logic signed [31:0] p_fix;

  logic [2*AW-1:0] q_sq, v_sq;
  logic [HW-1:0] hq, hv;
  logic signed [HW:0] hdiff;
  logic [HW-1:0] hmag;

  logic [AW+1:0] div_sh;
  logic [AW+2:0] div_trial;
  logic div_ok;

  logic [AW-1:0] offset;
  logic [2*AW-1:0] offset_sq;
  logic [24:0] sq_calc;
  logic sq_sat;

  logic [19:0] rt_sh;
  logic [20:0] rt_trial;
  logic rt_ok;
  logic [17:0] rt_rem_next;
  logic [15:0] rt_root_next;

  pedt_ram #(.Width(24), .Depth(2 ** AW)) u_cost (
    .clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  pedt_ram #(.Width(AW), .Depth(2 ** AW)) u_vtx (
    .clk, .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
  pedt_ram #(.Width(32), .Depth(2 ** AW)) u_bnd (
    .clk, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));

  assign pready = 1'b1;
  assign prdata = {31'd0, take_root};

  always_ff @(posedge clk) begin
    if (rst) begin
      take_root <= 1'b0;
    end else if (psel && penable && pwrite && paddr == pedt_pkg::RegTakeRoot) begin
      take_root <= pwdata[0];
    end
  end

  assign take_in = (state == pedt_pkg::ST_IDLE) && in_s.valid && !rst;
  assign accept_last = in_s.last || (count == AW'(MAX_LEN - 1));

  assign q_sq = q * q;
  assign v_sq = vtx * vtx;
  assign hq = HW'(cq) + HW'({q_sq, 8'd0});
  assign hv = HW'(c_rd) + HW'({v_sq, 8'd0});
  assign hdiff = $signed({1'b0, hq}) - $signed({1'b0, hv});
  assign hmag = hdiff[HW] ? HW'(-hdiff) : HW'(hdiff);

  assign div_sh = {rem, quo[DivW-1]};
  assign div_trial = {1'b0, div_sh} - {2'b00, den};
  assign div_ok = !div_trial[AW+2];

  always_comb begin
    if (!neg && (quo[32] || quo[31])) begin
      s_val = $signed(pedt_pkg::BndMax);
    end else if (neg && (quo[32] || (quo[31] && quo[30:0] != '0))) begin
      s_val = $signed(pedt_pkg::BndMin);
    end else if (neg) begin
      s_val = $signed(~quo[31:0] + 32'd1);
    end else begin
      s_val = $signed(quo[31:0]);
    end
  end

  assign pop = (k != '0) && (s_val <= bnd_k);
  assign p_fix = $signed({{(16 - AW){1'b0}}, p, 16'd0});
  assign step = (k < top) && ($signed(b_rd) < p_fix);

  assign offset = (p > cur_v) ? p - cur_v : cur_v - p;
  assign offset_sq = offset * offset;
  assign sq_calc = 25'({offset_sq, 8'd0}) + 25'(c_rd);
  assign sq_sat = sq_calc[24] || (sq_calc[23:0] == pedt_pkg::AllOnes);

  assign rt_sh = {rt_rem, rt_x[31:30]};
  assign rt_trial = {1'b0, rt_sh} - {3'b000, rt_root, 2'b01};
  assign rt_ok = !rt_trial[20];
  assign rt_rem_next = rt_ok ? rt_trial[17:0] : rt_sh[17:0];
  assign rt_root_next = {rt_root[14:0], rt_ok};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pedt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_s.ready = 1'b0;
    out_s.valid = 1'b0;
    c_we = 1'b0; c_wa = count; c_wd = in_s.cost; c_ra = v_rd;
    v_we = 1'b0; v_wa = k + AW'(1); v_wd = q; v_ra = k;
    b_we = 1'b0; b_wa = k + AW'(1); b_wd = s_val; b_ra = k;
    unique case (state)
      pedt_pkg::ST_IDLE: begin
        in_s.ready = !rst;
        v_ra = top;
        b_ra = top;
        v_wa = '0;
        v_wd = '0;
        if (take_in) begin
          c_we = 1'b1;
          if (count == '0) begin
            v_we = 1'b1;
            if (accept_last) state_next = pedt_pkg::ST_OUT_RD;
          end else begin
            state_next = pedt_pkg::ST_RD_OPS;
          end
        end
      end
      pedt_pkg::ST_RD_OPS: begin
        state_next = pedt_pkg::ST_RD_COST;
      end
      pedt_pkg::ST_RD_COST: begin
        state_next = pedt_pkg::ST_DIVIDE;
      end
      pedt_pkg::ST_DIVIDE: begin
        if (div_cnt == 6'd1) state_next = pedt_pkg::ST_DECIDE;
      end
      pedt_pkg::ST_DECIDE: begin
        if (pop) begin
          v_ra = k - AW'(1);
          b_ra = k - AW'(1);
          state_next = pedt_pkg::ST_RD_OPS;
        end else begin
          v_we = 1'b1;
          b_we = 1'b1;
          state_next = row_last ? pedt_pkg::ST_OUT_RD : pedt_pkg::ST_IDLE;
        end
      end
      pedt_pkg::ST_OUT_RD: begin
        b_ra = k + AW'(1);
        state_next = pedt_pkg::ST_OUT_VTX;
      end
      pedt_pkg::ST_OUT_VTX: begin
        state_next = step ? pedt_pkg::ST_OUT_RD : pedt_pkg::ST_OUT_CALC;
      end
      pedt_pkg::ST_OUT_CALC: begin
        state_next = (sq_sat || !take_root) ? pedt_pkg::ST_OUT_SEND : pedt_pkg::ST_OUT_ROOT;
      end
      pedt_pkg::ST_OUT_ROOT: begin
        if (rt_cnt == 5'd1) state_next = pedt_pkg::ST_OUT_SEND;
      end
      pedt_pkg::ST_OUT_SEND: begin
        out_s.valid = 1'b1;
        if (out_s.ready) state_next = (p == q) ? pedt_pkg::ST_IDLE : pedt_pkg::ST_OUT_RD;
      end
      default: state_next = pedt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      top <= '0;
      k <= '0;
      p <= '0;
      q <= '0;
      row_last <= 1'b0;
    end else begin
      unique case (state)
        pedt_pkg::ST_IDLE: begin
          if (take_in) begin
            q <= count;
            cq <= in_s.cost;
            row_last <= accept_last;
            p <= '0;
            if (count == '0) begin
              top <= '0;
              k <= '0;
              if (!accept_last) count <= AW'(1);
            end else begin
              k <= top;
            end
          end
        end
        pedt_pkg::ST_RD_OPS: begin
          vtx <= v_rd;
          bnd_k <= $signed(b_rd);
        end
        pedt_pkg::ST_RD_COST: begin
          neg <= hdiff[HW];
          quo <= {hmag, 8'd0};
          den <= {AW'(q - vtx), 1'b0};
          rem <= '0;
          div_cnt <= 6'(DivW);
        end
        pedt_pkg::ST_DIVIDE: begin
          rem <= div_ok ? div_trial[AW:0] : div_sh[AW:0];
          quo <= {quo[DivW-2:0], div_ok};
          div_cnt <= div_cnt - 6'd1;
        end
        pedt_pkg::ST_DECIDE: begin
          if (pop) begin
            k <= k - AW'(1);
          end else begin
            top <= k + AW'(1);
            k <= '0;
            if (row_last) count <= '0;
            else count <= count + AW'(1);
          end
        end
        pedt_pkg::ST_OUT_VTX: begin
          if (step) k <= k + AW'(1);
          else cur_v <= v_rd;
        end
        pedt_pkg::ST_OUT_CALC: begin
          res <= sq_sat ? pedt_pkg::AllOnes : sq_calc[23:0];
          rt_x <= {sq_calc[23:0], 8'd0};
          rt_rem <= '0;
          rt_root <= '0;
          rt_cnt <= 5'd16;
        end
        pedt_pkg::ST_OUT_ROOT: begin
          rt_rem <= rt_rem_next;
          rt_root <= rt_root_next;
          rt_x <= {rt_x[29:0], 2'b00};
          rt_cnt <= rt_cnt - 5'd1;
          if (rt_cnt == 5'd1) res <= {8'd0, rt_root_next};
        end
        pedt_pkg::ST_OUT_SEND: begin
          if (out_s.ready) p <= p + AW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_s.cost = res;
  assign out_s.last = (p == q);

endmodule
